[rtl/core/jfps_pkg.sv]
// ----------------------------------------------------------------------------
// jfps_pkg
// Shared constants and types of the Jacobi four-point stencil unit.
// ----------------------------------------------------------------------------
package jfps_pkg;

  // default sizing of the grid and the samples
  localparam int MAX_COLS_DEF    = 1024;
  localparam int MAX_ROWS_DEF    = 4096;
  localparam int SAMPLE_BITS_DEF = 16;

  // one ghost cell on each side of a row or a column
  localparam int GHOST_CELLS = 2;

  // register reset values
  localparam int COLS_RESET = 4;
  localparam int ROWS_RESET = 4;

  // configuration port
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;
  localparam int REG_SEL_LSB = 2;

  // result queue depth, a power of two of at least two
  localparam int QUEUE_DEPTH = 4;

  // register select decoded from the byte address
  typedef enum logic [0:0] {
    REG_COLS = 1'b0,
    REG_ROWS = 1'b1
  } reg_sel_t;

endpackage

[rtl/core/jacobi_four_point_stencil_unit.sv]
// ----------------------------------------------------------------------------
// jacobi_four_point_stencil_unit
// One Jacobi sweep over a streamed grid with a one-cell ghost border.
// ----------------------------------------------------------------------------
// Samples enter row-major on the sample channel (sample_valid/sample_stall),
// ghost rows and columns included. The transaction of cell (r, c) yields the
// new value of cell (r-1, c) on the result channel: the truncated quarter sum
// of its four neighbors for interior cells, the old value for border cells.
// Row 0 gives no result. On the last ghost row each transaction gives two
// results, the cell above and then the cell itself; frame_last marks the
// final one. Grid size is set through the APB port; every write restarts the
// grid at cell (0, 0).
// Each result is written into the result queue when its sample is taken.
// Throughput: one sample per cycle, while sample_stall is low, on all rows but
// the last ghost row; there the single result port fills the queue and stalls
// the samples. Line storage is one memory of column pairs, written and read
// once per transaction; a chain of window cells feeds the adder.
// Reset clears the position counters and the result queue and restores the
// 4 x 4 interior size. When the receiver stalls, results collect in a
// four-entry queue; sample_stall rises once fewer than two slots are free.
// ----------------------------------------------------------------------------
module jacobi_four_point_stencil_unit #(
  parameter int  MAX_COLS    = jfps_pkg::MAX_COLS_DEF,
  parameter int  MAX_ROWS    = jfps_pkg::MAX_ROWS_DEF,
  parameter int  SAMPLE_BITS = jfps_pkg::SAMPLE_BITS_DEF,
  localparam int COL_W       = $clog2(MAX_COLS + jfps_pkg::GHOST_CELLS),
  localparam int ROW_W       = $clog2(MAX_ROWS + jfps_pkg::GHOST_CELLS)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [jfps_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [jfps_pkg::APB_DATA_W-1:0] pwdata,
  output logic [jfps_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  input  logic                            sample_valid,
  output logic                            sample_stall,
  input  logic [SAMPLE_BITS-1:0]          sample,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [SAMPLE_BITS-1:0]          value,
  output logic [ROW_W-1:0]                row_index,
  output logic [COL_W-1:0]                col_index,
  output logic                            frame_last
);
  import jfps_pkg::*;

  localparam int SB         = SAMPLE_BITS;
  localparam int LINE_DEPTH = MAX_COLS + GHOST_CELLS;
  localparam int RES_W      = SB + ROW_W + COL_W + 1;

  logic [COL_W-1:0]  last_col;
  logic [ROW_W-1:0]  last_row;
  logic              restart;
  logic              accept;

  logic [ROW_W-1:0]  row_count;
  logic [ROW_W-1:0]  row_count_next;
  logic [COL_W-1:0]  col_count;
  logic [COL_W-1:0]  col_count_next;
  logic              wrap;
  logic              frame_end;

  logic [2*SB-1:0]   line_mem [LINE_DEPTH];
  logic [2*SB-1:0]   line_rd;
  logic [2*SB-1:0]   line_head;
  logic [COL_W:0]    col_plus2;
  logic [COL_W-1:0]  ahead_addr;

  logic [2*SB-1:0]   cur_q;
  logic [SB-1:0]     left_q;
  logic [SB-1:0]     up;
  logic [SB-1:0]     mid;
  logic [SB-1:0]     right;
  logic [SB+1:0]     sum;
  logic              inner;
  logic [SB-1:0]     new_val;
  logic              push0;
  logic              push1;
  logic [RES_W-1:0]  res0;
  logic [RES_W-1:0]  res1;
  logic              queue_stall;
  logic [RES_W-1:0]  head_data;

  // configuration registers
  jfps_cfg #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .last_col (last_col),
    .last_row (last_row),
    .restart  (restart)
  );

  assign sample_stall = queue_stall;
  assign accept       = sample_valid && !sample_stall;
  assign wrap         = col_count == last_col;
  assign frame_end    = wrap && (row_count == last_row);

  // position of the next sample
  always_comb begin
    row_count_next = row_count;
    col_count_next = col_count;
    if (restart) begin
      row_count_next = '0;
      col_count_next = '0;
    end else if (accept) begin
      if (wrap) begin
        col_count_next = '0;
        row_count_next = frame_end ? '0 : row_count + 1'b1;
      end else begin
        col_count_next = col_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else begin
      row_count <= row_count_next;
      col_count <= col_count_next;
    end
  end

  // column the memory fetches ahead: one past the next sample's column
  always_comb begin
    col_plus2 = {1'b0, col_count} + (COL_W + 1)'(2);
    if (wrap) begin
      ahead_addr = COL_W'(1);
    end else if (col_plus2 > {1'b0, last_col}) begin
      ahead_addr = '0;
    end else begin
      ahead_addr = col_plus2[COL_W-1:0];
    end
  end

  // line memory: each column holds {row r-1, row r-2} for the coming row
  always_ff @(posedge clk) begin
    if (accept) begin
      line_mem[col_count] <= {sample, mid};
      line_rd             <= line_mem[ahead_addr];
    end
  end

  // column 0 of the coming row, replayed into the window at a row wrap
  always_ff @(posedge clk) begin
    if (accept && (col_count == '0)) begin
      line_head <= {sample, mid};
    end
  end

  // window chain: fetched column -> current column -> left column
  jfps_cell #(
    .WIDTH (2 * SB)
  ) u_cell_cur (
    .clk     (clk),
    .en      (accept),
    .load    (wrap),
    .d_chain (line_rd),
    .d_load  (line_head),
    .q       (cur_q)
  );

  jfps_cell #(
    .WIDTH (SB)
  ) u_cell_left (
    .clk     (clk),
    .en      (accept),
    .load    (1'b0),
    .d_chain (mid),
    .d_load  ('0),
    .q       (left_q)
  );

  assign mid   = cur_q[2*SB-1:SB];
  assign up    = cur_q[SB-1:0];
  assign right = line_rd[2*SB-1:SB];

  // stencil arithmetic
  always_comb begin
    sum   = {2'b00, up} + {2'b00, left_q} + {2'b00, right} + {2'b00, sample};
    inner = (row_count > ROW_W'(1)) && (row_count <= last_row) &&
            (col_count != '0) && (col_count < last_col);
    new_val = inner ? sum[SB+1:2] : mid;
  end

  // results of this transaction
  assign push0 = accept && (row_count != '0);
  assign push1 = accept && (row_count == last_row);
  assign res0  = {new_val, row_count - 1'b1, col_count, 1'b0};
  assign res1  = {sample, row_count, col_count, wrap};

  jfps_outq #(
    .DATA_W (RES_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_outq (
    .clk       (clk),
    .rst       (rst),
    .push0     (push0),
    .push1     (push1),
    .d0        (res0),
    .d1        (res1),
    .in_stall  (queue_stall),
    .out_valid (result_valid),
    .out_stall (result_stall),
    .out_data  (head_data)
  );

  assign {value, row_index, col_index, frame_last} = head_data;

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    accept |-> col_count <= last_col && row_count <= last_row)
    else $error("position counter beyond grid");

  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    accept && frame_end && !restart |=> row_count == '0 && col_count == '0)
    else $error("counters did not return to the grid origin");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    restart |=> row_count == '0 && col_count == '0)
    else $error("register write did not restart the grid");

endmodule

[rtl/core/jfps_cfg.sv]
// ----------------------------------------------------------------------------
// jfps_cfg
// Register file of the grid size, with clamping and frame restart.
// ----------------------------------------------------------------------------
module jfps_cfg #(
  parameter int  MAX_COLS = jfps_pkg::MAX_COLS_DEF,
  parameter int  MAX_ROWS = jfps_pkg::MAX_ROWS_DEF,
  localparam int COL_W    = $clog2(MAX_COLS + jfps_pkg::GHOST_CELLS),
  localparam int ROW_W    = $clog2(MAX_ROWS + jfps_pkg::GHOST_CELLS)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [jfps_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [jfps_pkg::APB_DATA_W-1:0] pwdata,
  output logic [jfps_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  output logic [COL_W-1:0]                last_col,
  output logic [ROW_W-1:0]                last_row,
  output logic                            restart
);
  import jfps_pkg::*;

  logic [COL_W-1:0] raw_cols;
  logic [ROW_W-1:0] raw_rows;
  reg_sel_t         reg_sel;
  logic             wr_en;

  // zero counts as one, anything above the maximum as the maximum
  function automatic logic [COL_W-1:0] fit_cols(input logic [COL_W-1:0] v);
    logic [COL_W-1:0] r;
    if (v == '0) begin
      r = COL_W'(1);
    end else if (v > COL_W'(MAX_COLS)) begin
      r = COL_W'(MAX_COLS);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [ROW_W-1:0] fit_rows(input logic [ROW_W-1:0] v);
    logic [ROW_W-1:0] r;
    if (v == '0) begin
      r = ROW_W'(1);
    end else if (v > ROW_W'(MAX_ROWS)) begin
      r = ROW_W'(MAX_ROWS);
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign pready  = 1'b1;
  assign reg_sel = reg_sel_t'(paddr[REG_SEL_LSB]);
  assign wr_en   = psel && penable && pwrite && pready;
  // any write starts a new grid
  assign restart = wr_en;

  // raw registers and the derived last ghost column and row
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_cols <= COL_W'(COLS_RESET);
      raw_rows <= ROW_W'(ROWS_RESET);
      last_col <= fit_cols(COL_W'(COLS_RESET)) + 1'b1;
      last_row <= fit_rows(ROW_W'(ROWS_RESET)) + 1'b1;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_COLS: begin
          raw_cols <= pwdata[COL_W-1:0];
          last_col <= fit_cols(pwdata[COL_W-1:0]) + 1'b1;
        end
        REG_ROWS: begin
          raw_rows <= pwdata[ROW_W-1:0];
          last_row <= fit_rows(pwdata[ROW_W-1:0]) + 1'b1;
        end
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (reg_sel)
      REG_COLS: prdata = APB_DATA_W'(raw_cols);
      REG_ROWS: prdata = APB_DATA_W'(raw_rows);
    endcase
  end

endmodule

[rtl/core/jfps_cell.sv]
// ----------------------------------------------------------------------------
// jfps_cell
// One cell of the stencil window chain: takes its neighbor's word on every
// transaction, or an alternate word at the start of a row.
// ----------------------------------------------------------------------------
module jfps_cell #(
  parameter int WIDTH = 2 * jfps_pkg::SAMPLE_BITS_DEF
) (
  input  logic             clk,
  input  logic             en,
  input  logic             load,
  input  logic [WIDTH-1:0] d_chain,
  input  logic [WIDTH-1:0] d_load,
  output logic [WIDTH-1:0] q
);

  // shift from the neighbor, or reload at a row boundary
  always_ff @(posedge clk) begin
    if (en) begin
      q <= load ? d_load : d_chain;
    end
  end

endmodule

[rtl/core/jfps_outq.sv]
// ----------------------------------------------------------------------------
// jfps_outq
// Small result queue: takes up to two results per cycle, delivers one.
// ----------------------------------------------------------------------------
module jfps_outq #(
  parameter int DATA_W = 41,
  parameter int DEPTH  = jfps_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push0,
  input  logic              push1,
  input  logic [DATA_W-1:0] d0,
  input  logic [DATA_W-1:0] d1,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DATA_W-1:0] out_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] q_mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  wr_ptr_next;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic              pop;

  assign out_valid = count != '0;
  assign out_data  = q_mem[rd_ptr];
  assign pop       = out_valid && !out_stall;
  // room for two results is needed before the next transaction
  assign in_stall  = count > CNT_W'(DEPTH - 2);

  always_comb begin
    wr_ptr_next = wr_ptr + PTR_W'(push0) + PTR_W'(push1);
    count_next  = count + CNT_W'(push0) + CNT_W'(push1) - CNT_W'(pop);
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  // storage, the second result lands behind the first
  always_ff @(posedge clk) begin
    if (push0) begin
      q_mem[wr_ptr] <= d0;
    end
    if (push1) begin
      q_mem[PTR_W'(wr_ptr + 1'b1)] <= d1;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("result queue overflow");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> !push0 && !push1)
    else $error("result pushed while queue stalls input");

  a_push_order: assert property (@(posedge clk) disable iff (rst)
    push1 |-> push0)
    else $error("second result pushed without the first");

endmodule

[sim/jacobi_four_point_stencil_unit_test.sv]
// ----------------------------------------------------------------------------
// jacobi_four_point_stencil_unit_test
// Self-checking testbench for the streaming Jacobi four-point stencil unit.
// A behavioral predictor in this module tracks the line stores, the position
// counters and the grid size, and queues the expected cells for each sample
// taken. Every result is compared field by field against the oldest queued
// cell. Both channels idle at random; grid sizes are set over the APB port
// only when the unit is idle.
// ----------------------------------------------------------------------------
module jacobi_four_point_stencil_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import jfps_pkg::*;

  localparam int COL_W          = $clog2(MAX_COLS_DEF + GHOST_CELLS);
  localparam int ROW_W          = $clog2(MAX_ROWS_DEF + GHOST_CELLS);
  localparam int LINE_CELLS     = MAX_COLS_DEF + GHOST_CELLS;
  localparam int SETTLE_CYCLES  = 4;
  localparam int MAX_WAIT       = 5;
  localparam int RANDOM_SAMPLES = 150;
  localparam int REPORT_LIMIT   = 10;
  localparam int WIDE_EXTRA     = 8;
  localparam int TALL_ROWS      = 16;

  typedef logic [SAMPLE_BITS_DEF-1:0] sample_t;

  typedef struct packed {
    sample_t          value;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } cell_result_t;

  // unit ports
  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  psel         = 1'b0;
  logic                  penable      = 1'b0;
  logic                  pwrite       = 1'b0;
  logic [APB_ADDR_W-1:0] paddr        = '0;
  logic [APB_DATA_W-1:0] pwdata       = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  sample_valid = 1'b0;
  logic                  sample_stall;
  sample_t               sample       = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  sample_t               value;
  logic [ROW_W-1:0]      row_index;
  logic [COL_W-1:0]      col_index;
  logic                  frame_last;

  // predictor state: registers, line stores and position of the next sample
  logic [COL_W-1:0] cols_reg = COL_W'(COLS_RESET);
  logic [ROW_W-1:0] rows_reg = ROW_W'(ROWS_RESET);
  sample_t          prev_line  [LINE_CELLS] = '{default: '0};
  sample_t          prev2_line [LINE_CELLS] = '{default: '0};
  int               row_pos = 0;
  int               col_pos = 0;

  cell_result_t pending_cells[$];
  int           failures   = 0;
  int           stall_left = 0;
  bit           steady     = 1'b0;

  jacobi_four_point_stencil_unit dut (.*);

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void note_failure(string msg);
    failures++;
    if (failures <= REPORT_LIMIT) $display("mismatch: %s", msg);
  endfunction

  // register values as the unit uses them: zero means one, large values clamp
  function automatic int active_cols();
    if (cols_reg == 0) return 1;
    if (cols_reg > MAX_COLS_DEF) return MAX_COLS_DEF;
    return int'(cols_reg);
  endfunction

  function automatic int active_rows();
    if (rows_reg == 0) return 1;
    if (rows_reg > MAX_ROWS_DEF) return MAX_ROWS_DEF;
    return int'(rows_reg);
  endfunction

  // new value of the cell one row up, plus the own cell on the last ghost row
  task automatic sweep_cell(input sample_t s);
    int                       width;
    int                       last_row;
    int                       r;
    int                       c;
    sample_t                  up;
    sample_t                  mid;
    sample_t                  left;
    sample_t                  right;
    logic [SAMPLE_BITS_DEF+1:0] quad;
    cell_result_t             entry;
    width    = active_cols() + GHOST_CELLS;
    last_row = active_rows() + 1;
    r        = row_pos;
    c        = col_pos;
    // prev2 at c is row r-2, prev2 at c-1 already holds row r-1
    up    = prev2_line[c];
    mid   = prev_line[c];
    left  = (c > 0) ? prev2_line[c-1] : '0;
    right = (c + 1 < width) ? prev_line[c+1] : '0;
    if (r >= 1) begin
      // sum is taken at the width of quad, so no carry is lost
      quad        = up + left + right + s;
      entry.value = (r - 1 >= 1 && r - 1 <= active_rows() && c >= 1 && c <= active_cols())
                    ? quad[SAMPLE_BITS_DEF+1:2] : mid;
      entry.row   = ROW_W'(r - 1);
      entry.col   = COL_W'(c);
      entry.last  = 1'b0;
      pending_cells.push_back(entry);
    end
    if (r == last_row) begin
      entry.value = s;
      entry.row   = ROW_W'(r);
      entry.col   = COL_W'(c);
      entry.last  = (c == width - 1);
      pending_cells.push_back(entry);
    end
    prev2_line[c] = mid;
    prev_line[c]  = s;
    if (c + 1 >= width) begin
      col_pos = 0;
      row_pos = (r >= last_row) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  // one sample transaction, preceded by a random gap unless steady
  task automatic send_sample(input sample_t s);
    int gap;
    gap = steady ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= s;
    do @(posedge clk); while (sample_stall);
    sweep_cell(s);
  endtask

  // hold off the sender until every queued cell has come out
  task automatic drain_results();
    sample_valid <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_sel_t sel, input logic [APB_DATA_W-1:0] data);
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(int'(sel) << REG_SEL_LSB);
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (sel == REG_COLS) begin
      cols_reg = data[COL_W-1:0];
    end else begin
      rows_reg = data[ROW_W-1:0];
    end
    // any write restarts the grid, line stores keep their contents
    row_pos = 0;
    col_pos = 0;
  endtask

  // mostly in-range values, with extremes and raw 16-bit patterns mixed in
  function automatic sample_t draw_sample();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return sample_t'(32768);
      3, 4:    return sample_t'($urandom());
      default: return sample_t'($urandom_range(0, 32768));
    endcase
  endfunction

  task automatic send_frame(input int count);
    for (int i = 0; i < count; i++) send_sample(draw_sample());
  endtask

  // default 4 x 4 interior right after reset
  task automatic test_reset_size();
    send_frame((COLS_RESET + GHOST_CELLS) * (ROWS_RESET + GHOST_CELLS));
  endtask

  // smallest grid with corner values, then a 2 x 1 grid of all ones
  task automatic test_directed_extremes();
    sample_t corner_grid [9];
    corner_grid = '{16'h0000, 16'hFFFF, 16'h8000,
                    16'h7FFF, 16'hFFFF, 16'h0001,
                    16'h8000, 16'h0000, 16'hFFFF};
    write_reg(REG_COLS, 1);
    write_reg(REG_ROWS, 1);
    foreach (corner_grid[i]) send_sample(corner_grid[i]);
    write_reg(REG_COLS, 2);
    repeat (12) send_sample('1);
  endtask

  // widest row through an oversized column count: row 0, then the head of row 1
  task automatic test_widest_row();
    steady = 1'b1;
    write_reg(REG_COLS, ($urandom() << COL_W) | 32'(2**COL_W - 1));
    write_reg(REG_ROWS, 1);
    send_frame(LINE_CELLS + WIDE_EXTRA);
    steady = 1'b0;
  endtask

  // top of the tallest grid, cut short by the next write
  task automatic test_tallest_grid();
    steady = 1'b1;
    write_reg(REG_COLS, 1);
    write_reg(REG_ROWS, MAX_ROWS_DEF);
    send_frame(3 * TALL_ROWS);
    steady = 1'b0;
  endtask

  // zero sizes count as one, oversized rows clamp, upper data bits ignored
  task automatic test_out_of_range_sizes();
    write_reg(REG_COLS, 0);
    write_reg(REG_ROWS, 0);
    send_frame(9);
    steady = 1'b1;
    write_reg(REG_COLS, 1);
    write_reg(REG_ROWS, ($urandom() << ROW_W) | 32'(MAX_ROWS_DEF + 1));
    send_frame(3 * TALL_ROWS);
    steady = 1'b0;
  endtask

  // small random grids, some cut short, with occasional mid-frame drains
  task automatic test_random_grids();
    int sent;
    int full;
    int count;
    int ncols;
    sent = 0;
    while (sent < RANDOM_SAMPLES) begin
      steady = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 3) != 0) begin
        ncols = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 8) : $urandom_range(9, 24);
        write_reg(REG_COLS, ncols);
      end
      write_reg(REG_ROWS, $urandom_range(1, 6));
      full  = (active_cols() + GHOST_CELLS) * (active_rows() + GHOST_CELLS);
      count = ($urandom_range(0, 5) == 0) ? $urandom_range(1, full - 1) : full;
      for (int i = 0; i < count; i++) begin
        if ($urandom_range(0, 59) == 0) drain_results();
        send_sample(draw_sample());
      end
      sent += count;
    end
    steady = 1'b0;
  endtask

  // result side: compare each transaction, then draw the next stall
  always @(posedge clk) begin : result_check
    cell_result_t want;
    if (rst) begin
      result_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (pending_cells.size() == 0) begin
          note_failure($sformatf("unexpected cell value=%0d row=%0d col=%0d last=%0b",
                                 value, row_index, col_index, frame_last));
        end else begin
          want = pending_cells.pop_front();
          if (value !== want.value || row_index !== want.row ||
              col_index !== want.col || frame_last !== want.last) begin
            note_failure($sformatf(
              "expected value=%0d row=%0d col=%0d last=%0b, got value=%0d row=%0d col=%0d last=%0b",
              want.value, want.row, want.col, want.last,
              value, row_index, col_index, frame_last));
          end
        end
        stall_left = steady ? 0 : $urandom_range(0, MAX_WAIT);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      result_stall <= (stall_left > 0);
    end
  end

  // test sequence
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_size();
    test_directed_extremes();
    test_widest_row();
    test_tallest_grid();
    test_out_of_range_sizes();
    test_random_grids();
    drain_results();
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[sim.f]
rtl/core/jfps_pkg.sv
rtl/core/jfps_cfg.sv
rtl/core/jfps_cell.sv
rtl/core/jfps_outq.sv
rtl/core/jacobi_four_point_stencil_unit.sv
sim/jacobi_four_point_stencil_unit_test.sv
